// File: rtl/core/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
// Holds field widths, operation and status codes, and bitmap row geometry.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    // Bitmap row geometry: one RAM word covers WORD_W blocks
    localparam int WORD_W = 64;
    localparam int BIT_W  = 6;

    // Default capacity of the bitmap
    localparam int MAX_BLOCKS_DEF = 4096;

    // Port field widths
    localparam int OP_W      = 2;
    localparam int IDX_IN_W  = 13;
    localparam int CFG_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int FOUND_W   = 12;
    localparam int CNT_OUT_W = 13;

    // Block count after reset
    localparam int CFG_RESET = 4096;

    typedef enum logic [OP_W-1:0] {
        OP_MARK_USED = 2'd0,
        OP_MARK_FREE = 2'd1,
        OP_CHECK     = 2'd2,
        OP_FIND      = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_STATE = 2'd2
    } t_status;

endpackage

`default_nettype wire

// File: rtl/core/bba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter  int WIDTH = 64,
    parameter  int DEPTH = 64,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/bba_row_search.sv
// Lowest-free-bit search over one bitmap row, optionally from a start bit.
// Depends on bba_pkg for the row geometry.
`timescale 1ns / 1ps
`default_nettype none

module bba_row_search (
    input  wire logic [bba_pkg::WORD_W-1:0] i_word,
    input  wire logic [bba_pkg::BIT_W-1:0]  i_from,
    input  wire logic                       i_use_from,
    output logic                            o_hit,
    output logic      [bba_pkg::BIT_W-1:0]  o_pos
);

    localparam int WORD_W = bba_pkg::WORD_W;
    localparam int BIT_W  = bba_pkg::BIT_W;

    logic [WORD_W-1:0] low_mask;
    logic [WORD_W-1:0] free_bits;
    logic [WORD_W-1:0] lowest;

    // Mask off bits below the start, keep free bits, isolate the lowest one
    always_comb begin
        low_mask  = i_use_from ? ((WORD_W'(1) << i_from) - WORD_W'(1)) : '0;
        free_bits = ~i_word & ~low_mask;
        lowest    = free_bits & (~free_bits + WORD_W'(1));
        o_hit     = |free_bits;
    end

    // Encode the one-hot lowest bit
    always_comb begin
        o_pos = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (lowest[k]) begin
                o_pos = o_pos | BIT_W'(k);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/block_bitmap_allocator_core.sv
// Top level of the block bitmap allocator: sequencer, counters, first-free pointer.
// Depends on bba_pkg, bba_ram and bba_row_search.
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | i_in_valid, o_in_stall, i_op, i_block_index | in
//  result   | o_out_valid, i_out_stall, o_status, o_found_index,
//           | o_found_valid, o_free_count, o_first_free, o_first_free_valid | out
//  config   | i_cfg_we, i_cfg_data (block count)         | in
//
// Mark used, mark free, check and out-of-range ops pass from transfer through the
// EXEC and HOLD states to the output register. Find free, and mark used of the first
// free block, add a row scan through the bitmap RAM at one 64-bit row a cycle.
// After reset and after each config write a clearing pass writes zero to every
// row of the bitmap RAM, with the input stalled.
// A finished result waits in the output register while the next item transfers.
`timescale 1ns / 1ps
`default_nettype none

module block_bitmap_allocator_core #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bba_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [bba_pkg::OP_W-1:0]        i_op,
    input  wire logic [bba_pkg::IDX_IN_W-1:0]    i_block_index,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic      [bba_pkg::STATUS_W-1:0]    o_status,
    output logic      [bba_pkg::FOUND_W-1:0]     o_found_index,
    output logic                                 o_found_valid,
    output logic      [bba_pkg::CNT_OUT_W-1:0]   o_free_count,
    output logic      [bba_pkg::FOUND_W-1:0]     o_first_free,
    output logic                                 o_first_free_valid
);

    localparam int WORD_W  = bba_pkg::WORD_W;
    localparam int BIT_W   = bba_pkg::BIT_W;
    localparam int ROWS    = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int SROW_W  = $clog2(ROWS + 1);
    localparam int IDX_W   = $clog2(MAX_BLOCKS);
    localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
    localparam int HIT_W   = SROW_W + BIT_W;
    localparam int RST_EFF = (bba_pkg::CFG_RESET > MAX_BLOCKS) ? MAX_BLOCKS
                                                               : bba_pkg::CFG_RESET;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_SCAN  = 5'b01000,
        S_HOLD  = 5'b10000
    } t_state;

    // Sequencer and allocator state
    t_state                      r_state, n_state;
    logic [ROW_W-1:0]            r_clr_row, n_clr_row;
    logic [CNT_W-1:0]            r_eff, n_eff;
    logic [CNT_W-1:0]            r_free, n_free;
    logic [IDX_W-1:0]            r_ptr, n_ptr;
    logic                        r_ok, n_ok;

    // Current item and scan position
    bba_pkg::t_op                r_op, n_op;
    logic [bba_pkg::IDX_IN_W-1:0] r_idx, n_idx;
    logic [SROW_W-1:0]           r_row, n_row;
    logic [BIT_W-1:0]            r_sbit, n_sbit;
    logic                        r_first, n_first;

    // Result waiting for the output register
    bba_pkg::t_status            r_res_status, n_res_status;
    logic [bba_pkg::FOUND_W-1:0] r_res_found, n_res_found;
    logic                        r_res_fv, n_res_fv;

    // Output register
    logic                        r_out_valid, n_out_valid;
    bba_pkg::t_status            r_out_status;
    logic [bba_pkg::FOUND_W-1:0] r_out_found;
    logic                        r_out_fv;
    logic [CNT_W-1:0]            r_out_free;
    logic [IDX_W-1:0]            r_out_ptr;
    logic                        r_out_ok;

    // RAM and search wiring
    logic                        ram_we;
    logic [ROW_W-1:0]            ram_waddr;
    logic [WORD_W-1:0]           ram_wdata;
    logic [WORD_W-1:0]           ram_rdata;
    logic                        s_hit;
    logic [BIT_W-1:0]            s_pos;

    logic                        in_xfer;
    logic                        out_load;
    logic [CNT_W-1:0]            cfg_eff;
    logic                        cur_bit;
    logic [WORD_W-1:0]           bit_sel;
    logic                        in_range;
    logic [31:0]                 next_idx;
    logic                        row_beyond;
    logic [HIT_W-1:0]            glob;
    logic                        glob_ok;

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ROW_W'(n_row)),
        .o_rdata (ram_rdata)
    );

    bba_row_search u_search (
        .i_word     (ram_rdata),
        .i_from     (r_sbit),
        .i_use_from (r_first),
        .o_hit      (s_hit),
        .o_pos      (s_pos)
    );

    // Decode handshakes and row-level conditions
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        in_xfer    = i_in_valid && !o_in_stall;
        out_load   = (r_state == S_HOLD) && (!r_out_valid || !i_out_stall);
        cfg_eff    = (32'(i_cfg_data) > 32'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                         : CNT_W'(i_cfg_data);
        bit_sel    = WORD_W'(1) << r_idx[BIT_W-1:0];
        cur_bit    = |(ram_rdata & bit_sel);
        in_range   = 32'(r_idx) < 32'(r_eff);
        next_idx   = 32'(r_idx) + 32'd1;
        row_beyond = (32'(r_row) << BIT_W) >= 32'(r_eff);
        glob       = {r_row, s_pos};
        glob_ok    = 32'(glob) < 32'(r_eff);
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_clr_row    = r_clr_row;
        n_eff        = r_eff;
        n_free       = r_free;
        n_ptr        = r_ptr;
        n_ok         = r_ok;
        n_op         = r_op;
        n_idx        = r_idx;
        n_row        = r_row;
        n_sbit       = r_sbit;
        n_first      = r_first;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_res_fv     = r_res_fv;
        ram_we       = 1'b0;
        ram_waddr    = ROW_W'(r_row);
        ram_wdata    = ram_rdata;

        case (r_state)
            S_CLEAR: begin
                // Zero one row a cycle
                ram_we    = 1'b1;
                ram_waddr = r_clr_row;
                ram_wdata = '0;
                n_clr_row = r_clr_row + ROW_W'(1);
                if (32'(r_clr_row) == ROWS - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // Take the item and start the read of its row
                if (in_xfer) begin
                    n_op    = bba_pkg::t_op'(i_op);
                    n_idx   = i_block_index;
                    n_row   = SROW_W'(32'(i_block_index) >> BIT_W);
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res_status = bba_pkg::ST_OK;
                n_res_found  = '0;
                n_res_fv     = 1'b0;
                n_state      = S_HOLD;
                if (!in_range) begin
                    n_res_status = bba_pkg::ST_RANGE;
                end else begin
                    case (r_op)
                        bba_pkg::OP_MARK_USED: begin
                            if (cur_bit) begin
                                n_res_status = bba_pkg::ST_STATE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = ram_rdata | bit_sel;
                                if (r_free != '0) begin
                                    n_free = r_free - CNT_W'(1);
                                end
                                // Move the pointer past the block just taken
                                if (r_ok && (32'(r_idx) == 32'(r_ptr))) begin
                                    n_row   = SROW_W'(next_idx >> BIT_W);
                                    n_sbit  = BIT_W'(next_idx);
                                    n_first = 1'b1;
                                    n_state = S_SCAN;
                                end
                            end
                        end
                        bba_pkg::OP_MARK_FREE: begin
                            if (!cur_bit) begin
                                n_res_status = bba_pkg::ST_STATE;
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = ram_rdata & ~bit_sel;
                                if (!r_ok || (32'(r_idx) < 32'(r_ptr))) begin
                                    n_ptr = IDX_W'(r_idx);
                                    n_ok  = 1'b1;
                                end
                                if (r_free < r_eff) begin
                                    n_free = r_free + CNT_W'(1);
                                end
                            end
                        end
                        bba_pkg::OP_CHECK: begin
                            n_res_fv = cur_bit;
                        end
                        bba_pkg::OP_FIND: begin
                            n_sbit  = r_idx[BIT_W-1:0];
                            n_first = 1'b1;
                            n_state = S_SCAN;
                        end
                        default: begin
                            n_res_status = bba_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // Examine one row a cycle until a free block or the end
                if (row_beyond || s_hit) begin
                    n_state = S_HOLD;
                    if (r_op == bba_pkg::OP_FIND) begin
                        if (!row_beyond && glob_ok) begin
                            n_res_found = bba_pkg::FOUND_W'(glob);
                            n_res_fv    = 1'b1;
                        end
                    end else if (!row_beyond && glob_ok) begin
                        n_ptr = IDX_W'(glob);
                    end else begin
                        n_ptr = '0;
                        n_ok  = 1'b0;
                    end
                end else begin
                    n_row   = r_row + SROW_W'(1);
                    n_first = 1'b0;
                end
            end
            S_HOLD: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Register write: set the count, restart the bitmap
        if (i_cfg_we) begin
            n_eff     = cfg_eff;
            n_free    = cfg_eff;
            n_ptr     = '0;
            n_ok      = (cfg_eff != '0);
            n_clr_row = '0;
            n_state   = S_CLEAR;
        end
    end

    // Output register valid: load from hold, drop on transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_row   <= '0;
            r_eff       <= CNT_W'(RST_EFF);
            r_free      <= CNT_W'(RST_EFF);
            r_ptr       <= '0;
            r_ok        <= (RST_EFF != 0);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_row   <= n_clr_row;
            r_eff       <= n_eff;
            r_free      <= n_free;
            r_ptr       <= n_ptr;
            r_ok        <= n_ok;
            r_out_valid <= n_out_valid;
        end
    end

    // Item, scan and result payload
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_row        <= n_row;
        r_sbit       <= n_sbit;
        r_first      <= n_first;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_res_fv     <= n_res_fv;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_found  <= r_res_found;
            r_out_fv     <= r_res_fv;
            r_out_free   <= r_free;
            r_out_ptr    <= r_ptr;
            r_out_ok     <= r_ok;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_out_status;
    assign o_found_index      = r_out_found;
    assign o_found_valid      = r_out_fv;
    assign o_free_count       = bba_pkg::CNT_OUT_W'(r_out_free);
    assign o_first_free       = r_out_ok ? bba_pkg::FOUND_W'(r_out_ptr) : '0;
    assign o_first_free_valid = r_out_ok;

    // Checks on allocator bookkeeping
    a_out_from_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_HOLD))
        else $error("result loaded outside hold state");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_eff)
        else $error("free count above block count");

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ok |-> (32'(r_ptr) < 32'(r_eff)))
        else $error("first-free pointer outside block range");

    a_ptr_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ok |-> (r_ptr == '0))
        else $error("pointer not zero with no free block known");

endmodule

`default_nettype wire

// File: verif/tb_block_bitmap_allocator_core.sv
// Self-checking testbench for block_bitmap_allocator_core.
// Drives a directed table and then random phases of bitmap operations, predicts every
// result in a local bitmap model. Depends on bba_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_block_bitmap_allocator_core;
    import bba_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RST_CYCLES    = 12;
    localparam int CAPACITY      = MAX_BLOCKS_DEF;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 100;
    localparam int TIMEOUT_NS    = 5_000_000;

    typedef struct packed {
        t_status                status;
        logic [FOUND_W-1:0]     found_index;
        logic                   found_valid;
        logic [CNT_OUT_W-1:0]   free_count;
        logic [FOUND_W-1:0]     first_free;
        logic                   first_free_valid;
    } alloc_result_t;

    typedef struct {
        bit                     is_cfg;
        logic [CFG_W-1:0]       cfg_value;
        t_op                    op;
        logic [IDX_IN_W-1:0]    index;
        bit                     fixed;
        alloc_result_t          want;
    } dir_row_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_W-1:0]       i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [OP_W-1:0]        i_op;
    logic [IDX_IN_W-1:0]    i_block_index;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [STATUS_W-1:0]    o_status;
    logic [FOUND_W-1:0]     o_found_index;
    logic                   o_found_valid;
    logic [CNT_OUT_W-1:0]   o_free_count;
    logic [FOUND_W-1:0]     o_first_free;
    logic                   o_first_free_valid;

    // Local copy of the allocator state
    bit                     blk_used [CAPACITY];
    logic [CFG_W-1:0]       mdl_count_reg;
    int unsigned            mdl_free;
    int unsigned            mdl_ptr;
    bit                     mdl_ptr_ok;

    alloc_result_t          pending_results [$];
    dir_row_t               directed_rows [$];

    int unsigned            err_count     = 0;
    int unsigned            items_sent    = 0;
    int unsigned            results_seen  = 0;
    int unsigned            cfg_writes    = 0;
    int                     hold_requests = 0;
    bit                     tx_gaps       = 1'b1;
    bit                     rx_gaps       = 1'b1;

    block_bitmap_allocator_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_op               (i_op),
        .i_block_index      (i_block_index),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_status           (o_status),
        .o_found_index      (o_found_index),
        .o_found_valid      (o_found_valid),
        .o_free_count       (o_free_count),
        .o_first_free       (o_first_free),
        .o_first_free_valid (o_first_free_valid)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("tb_block_bitmap_allocator_core: FAIL");
        $finish;
    end

    // ---------------------------------------------------------------- prediction

    function automatic int unsigned live_count();
        return (mdl_count_reg > CAPACITY) ? CAPACITY : int'(mdl_count_reg);
    endfunction

    function automatic void load_block_count(input logic [CFG_W-1:0] value);
        mdl_count_reg = value;
        foreach (blk_used[i]) blk_used[i] = 1'b0;
        mdl_free   = live_count();
        mdl_ptr    = 0;
        mdl_ptr_ok = (live_count() != 0);
    endfunction

    // Lowest free block in [from, count), if any
    function automatic bit scan_free_from(input int unsigned from, output int unsigned hit);
        int unsigned n;
        int unsigned i;
        n   = live_count();
        hit = 0;
        for (i = from; i < n; i++) begin
            if (!blk_used[i]) begin
                hit = i;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one operation to the local bitmap and return the result it yields
    function automatic alloc_result_t apply_alloc_op(input t_op op, input int unsigned idx);
        alloc_result_t r;
        int unsigned   n;
        int unsigned   hit;
        r = '0;
        r.status = ST_OK;
        n = live_count();
        if (idx >= n) begin
            r.status = ST_RANGE;
        end else begin
            case (op)
                OP_MARK_USED: begin
                    if (blk_used[idx]) begin
                        r.status = ST_STATE;
                    end else begin
                        // advance the pointer past a block that is taken
                        if (mdl_ptr_ok && idx == mdl_ptr) begin
                            if (scan_free_from(idx + 1, hit)) begin
                                mdl_ptr = hit;
                            end else begin
                                mdl_ptr    = 0;
                                mdl_ptr_ok = 1'b0;
                            end
                        end
                        blk_used[idx] = 1'b1;
                        if (mdl_free > 0) mdl_free--;
                    end
                end
                OP_MARK_FREE: begin
                    if (!blk_used[idx]) begin
                        r.status = ST_STATE;
                    end else begin
                        blk_used[idx] = 1'b0;
                        if (!mdl_ptr_ok || idx < mdl_ptr) begin
                            mdl_ptr    = idx;
                            mdl_ptr_ok = 1'b1;
                        end
                        if (mdl_free < n) mdl_free++;
                    end
                end
                OP_CHECK: begin
                    r.found_valid = blk_used[idx];
                end
                OP_FIND: begin
                    if (scan_free_from(idx, hit)) begin
                        r.found_index = FOUND_W'(hit);
                        r.found_valid = 1'b1;
                    end
                end
            endcase
        end
        r.free_count       = CNT_OUT_W'(mdl_free);
        r.first_free       = mdl_ptr_ok ? FOUND_W'(mdl_ptr) : '0;
        r.first_free_valid = mdl_ptr_ok;
        return r;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        err_count++;
        $display("[%0t] mismatch on %s: got %0d, want %0d (result %0d)",
                 $time, what, got, want, results_seen);
    endtask

    task automatic check_result(input alloc_result_t got, input alloc_result_t want);
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.found_index !== want.found_index)
            report_mismatch("found_index", got.found_index, want.found_index);
        if (got.found_valid !== want.found_valid)
            report_mismatch("found_valid", got.found_valid, want.found_valid);
        if (got.free_count !== want.free_count)
            report_mismatch("free_count", got.free_count, want.free_count);
        if (got.first_free !== want.first_free)
            report_mismatch("first_free", got.first_free, want.first_free);
        if (got.first_free_valid !== want.first_free_valid)
            report_mismatch("first_free_valid", got.first_free_valid, want.first_free_valid);
    endtask

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        alloc_result_t got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.status           = t_status'(o_status);
            got.found_index      = o_found_index;
            got.found_valid      = o_found_valid;
            got.free_count       = o_free_count;
            got.first_free       = o_first_free;
            got.first_free_valid = o_first_free_valid;
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", results_seen, 0);
            else
                check_result(got, pending_results.pop_front());
        end
    end

    // ---------------------------------------------------------------- result side stall

    initial begin : result_stall
        int unsigned burst;
        int          hold_seen;
        i_out_stall = 1'b0;
        hold_seen   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_requests) begin
                // hold off long enough for the block to back up into its input
                hold_seen   = hold_requests;
                i_out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_out_stall = 1'b0;
            end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
                burst       = $urandom_range(1, 4);
                i_out_stall = 1'b1;
                repeat (burst) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // Offer one item, hold it until transfer, then predict its result
    task automatic send_item(input t_op op, input int unsigned idx, input bit fixed,
                             input alloc_result_t want);
        alloc_result_t expv;
        int unsigned   gap;
        @(negedge i_clk);
        i_in_valid    = 1'b1;
        i_op          = op;
        i_block_index = IDX_IN_W'(idx);
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        expv = apply_alloc_op(op, idx);
        if (fixed) expv = want;
        pending_results.push_back(expv);
        items_sent++;
        if (tx_gaps && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_results_done();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_block_count(input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_cfg_we   = 1'b1;
        i_cfg_data = value;
        load_block_count(value);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    // Start a table row with every field cleared and the op set to check
    function automatic dir_row_t blank_row();
        dir_row_t row;
        row.is_cfg    = 1'b0;
        row.cfg_value = '0;
        row.op        = OP_CHECK;
        row.index     = '0;
        row.fixed     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic void row_cfg(input logic [CFG_W-1:0] value);
        dir_row_t row;
        row           = blank_row();
        row.is_cfg    = 1'b1;
        row.cfg_value = value;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_item(input t_op op, input int unsigned idx);
        dir_row_t row;
        row       = blank_row();
        row.op    = op;
        row.index = IDX_IN_W'(idx);
        directed_rows.push_back(row);
    endfunction

    function automatic void row_fixed(input t_op op, input int unsigned idx,
                                      input t_status st, input int unsigned fidx,
                                      input bit fval, input int unsigned fcnt,
                                      input int unsigned ff, input bit ffval);
        dir_row_t row;
        row       = blank_row();
        row.op    = op;
        row.index = IDX_IN_W'(idx);
        row.fixed = 1'b1;
        row.want.status           = st;
        row.want.found_index      = FOUND_W'(fidx);
        row.want.found_valid      = fval;
        row.want.free_count       = CNT_OUT_W'(fcnt);
        row.want.first_free       = FOUND_W'(ff);
        row.want.first_free_valid = ffval;
        directed_rows.push_back(row);
    endfunction

    // One random phase: set the block count, fill first, then mix frees and scans
    task automatic run_phase(input logic [CFG_W-1:0] count_val, input int unsigned n_items,
                             input bit press, input bit drain_mid);
        int unsigned k;
        int unsigned n;
        int unsigned p;
        int unsigned q;
        int unsigned idx;
        bit          fill;
        bit          saved_gaps;
        t_op         op;
        saved_gaps = tx_gaps;
        wait_results_done();
        write_block_count(count_val);
        if (press) hold_requests++;
        for (k = 0; k < n_items; k++) begin
            if (drain_mid && k == n_items / 2) wait_results_done();
            tx_gaps = (press && k < 40) ? 1'b0 : saved_gaps;
            fill = (k < n_items / 2);
            n    = live_count();
            q    = $urandom_range(0, 99);
            if (fill)
                op = (q < 50) ? OP_MARK_USED : (q < 65) ? OP_MARK_FREE :
                     (q < 80) ? OP_CHECK : OP_FIND;
            else
                op = (q < 25) ? OP_MARK_USED : (q < 60) ? OP_MARK_FREE :
                     (q < 75) ? OP_CHECK : OP_FIND;
            // aim at the first-free block, the live range, its edge, or anywhere
            p = $urandom_range(0, 99);
            if (p < 15 && mdl_ptr_ok)
                idx = mdl_ptr;
            else if (p < 85 && n > 0)
                idx = $urandom_range(0, n - 1);
            else if (p < 95)
                idx = (n == 0) ? $urandom_range(0, 2) : n - 1 + $urandom_range(0, 2);
            else
                idx = $urandom_range(0, (1 << IDX_IN_W) - 1);
            send_item(op, idx, 1'b0, '0);
        end
        tx_gaps = saved_gaps;
    endtask

    initial begin : main_seq
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_op          = OP_CHECK;
        i_block_index = '0;
        load_block_count(CFG_RESET);

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // State after reset, index extremes, refusals, pointer moves
        row_fixed(OP_CHECK,     0,    ST_OK,    0,    0, 4096, 0, 1);
        row_fixed(OP_FIND,      0,    ST_OK,    0,    1, 4096, 0, 1);
        row_fixed(OP_MARK_USED, 4096, ST_RANGE, 0,    0, 4096, 0, 1);
        row_fixed(OP_MARK_USED, 8191, ST_RANGE, 0,    0, 4096, 0, 1);
        row_fixed(OP_MARK_FREE, 0,    ST_STATE, 0,    0, 4096, 0, 1);
        row_fixed(OP_MARK_USED, 0,    ST_OK,    0,    0, 4095, 1, 1);
        row_fixed(OP_MARK_USED, 0,    ST_STATE, 0,    0, 4095, 1, 1);
        row_fixed(OP_CHECK,     0,    ST_OK,    0,    1, 4095, 1, 1);
        row_fixed(OP_MARK_USED, 4095, ST_OK,    0,    0, 4094, 1, 1);
        row_fixed(OP_FIND,      4095, ST_OK,    0,    0, 4094, 1, 1);
        row_fixed(OP_FIND,      4094, ST_OK,    4094, 1, 4094, 1, 1);
        row_item(OP_MARK_USED, 1);
        row_item(OP_MARK_FREE, 0);
        // Single block: fill it, then free it with no free block known
        row_cfg(13'd1);
        row_fixed(OP_MARK_USED, 0,    ST_OK,    0,    0, 0,    0, 0);
        row_fixed(OP_FIND,      0,    ST_OK,    0,    0, 0,    0, 0);
        row_fixed(OP_MARK_USED, 1,    ST_RANGE, 0,    0, 0,    0, 0);
        row_fixed(OP_MARK_FREE, 0,    ST_OK,    0,    0, 1,    0, 1);
        // Zero blocks: everything is out of range
        row_cfg(13'd0);
        row_fixed(OP_CHECK,     0,    ST_RANGE, 0,    0, 0,    0, 0);
        row_fixed(OP_FIND,      0,    ST_RANGE, 0,    0, 0,    0, 0);
        // Count above capacity saturates
        row_cfg(13'd8191);
        row_fixed(OP_MARK_USED, 4095, ST_OK,    0,    0, 4095, 0, 1);
        row_fixed(OP_CHECK,     4096, ST_RANGE, 0,    0, 4095, 0, 1);
        // Walk the pointer to exhaustion and back
        row_cfg(13'd3);
        row_item(OP_MARK_USED, 2);
        row_item(OP_MARK_USED, 0);
        row_fixed(OP_MARK_USED, 1,    ST_OK,    0,    0, 0,    0, 0);
        row_item(OP_MARK_FREE, 2);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].is_cfg) begin
                wait_results_done();
                write_block_count(directed_rows[r].cfg_value);
            end else begin
                send_item(directed_rows[r].op, directed_rows[r].index,
                          directed_rows[r].fixed, directed_rows[r].want);
            end
        end

        // Random phases, mostly small counts
        run_phase(13'd64,   64, 1'b0, 1'b0);
        run_phase(13'd5,    60, 1'b0, 1'b0);
        run_phase(13'd130,  70, 1'b1, 1'b0);
        run_phase(13'd4096, 32, 1'b0, 1'b0);
        run_phase(13'd1,    40, 1'b0, 1'b0);
        run_phase(13'd0,    24, 1'b0, 1'b0);
        run_phase(13'd8191, 32, 1'b0, 1'b0);
        run_phase(13'd33,   80, 1'b0, 1'b1);
        run_phase(13'd200,  90, 1'b0, 1'b0);
        run_phase(13'd16,   70, 1'b0, 1'b0);
        run_phase(13'd2,    40, 1'b0, 1'b0);
        // Closing stretch at full rate on both sides
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_phase(13'd64,   90, 1'b0, 1'b0);

        // Drain, then watch for stray results
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d operation transfers across %0d block-count settings,",
                 items_sent, cfg_writes + 1);
        $display("with %0d results compared and %0d mismatches.", results_seen, err_count);
        if (err_count == 0) begin
            $display("tb_block_bitmap_allocator_core: PASS");
        end else begin
            $display("tb_block_bitmap_allocator_core: FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_row_search.sv
rtl/core/block_bitmap_allocator_core.sv
verif/tb_block_bitmap_allocator_core.sv
